// File: rtl/core/jd3_pkg.sv
// shared types, constants and helpers for the 3d jacobi diffusion block
`default_nettype none
package jd3_pkg;

    // extents are held in 5-bit registers, so no axis exceeds this
    localparam int EXT_LIMIT = 31;
    // default grid limits
    localparam int DEF_MAX_X = 16;
    localparam int DEF_MAX_Y = 16;
    localparam int DEF_MAX_Z = 16;

    // field and datapath widths
    localparam int SIZE_W  = 5;
    localparam int XY_W    = 2 * SIZE_W;
    localparam int CNT_W   = 3 * SIZE_W;
    localparam int IDX_W   = 12;
    localparam int DATA_W  = 32;
    localparam int SWEEP_W = 8;
    localparam int COUP_W  = 24;
    localparam int DIAG_W  = 17;
    localparam int CFG_W   = 24;
    localparam int SUM_W   = 35;
    localparam int MAC_A_W = 54;
    localparam int MAC_B_W = 24;
    localparam int CHUNK_W = 18;
    localparam int ACC_W   = 64;
    localparam int RND_W   = ACC_W - 16;

    // configuration register indexes
    localparam logic [2:0] CFG_SIZE_X = 3'd0;
    localparam logic [2:0] CFG_SIZE_Y = 3'd1;
    localparam logic [2:0] CFG_SIZE_Z = 3'd2;
    localparam logic [2:0] CFG_SWEEPS = 3'd3;
    localparam logic [2:0] CFG_COUP   = 3'd4;
    localparam logic [2:0] CFG_DIAG   = 3'd5;

    // configuration reset values
    localparam logic [SIZE_W-1:0]  RST_SIZE   = 5'd16;
    localparam logic [SWEEP_W-1:0] RST_SWEEPS = 8'd20;
    localparam logic [COUP_W-1:0]  RST_COUP   = 24'd0;
    localparam logic [DIAG_W-1:0]  RST_DIAG   = 17'd65536;

    // action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_RUN   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP_XY,
        ST_PREP_N,
        ST_DISPATCH,
        ST_READ_WAIT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_CELL,
        ST_NB,
        ST_MUL1_GO,
        ST_MUL1_WAIT,
        ST_MUL2_GO,
        ST_MUL2_WAIT
    } state_t;

    // memory control group from sequencer to store
    typedef struct packed {
        logic src_we;
        logic it_we;
        logic it_wsel;
        logic it_rsel;
    } mem_ctl_t;

    // effective extent: zero acts as one, large values clamp
    function automatic logic [SIZE_W-1:0] extent(input logic [SIZE_W-1:0] r,
                                                 input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] e;
        begin
            if (r == '0)
                e = SIZE_W'(1);
            else if (r > lim)
                e = lim;
            else
                e = r;
            return e;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/jd3_mac.sv
// shared multiply-accumulate unit, one 18-bit chunk per cycle
`default_nettype none
module jd3_mac (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 go,
    input  wire logic signed [jd3_pkg::MAC_A_W-1:0]   a,
    input  wire logic        [jd3_pkg::MAC_B_W-1:0]   b,
    output logic                                      valid,
    output logic signed [jd3_pkg::ACC_W-1:0]          acc
);
    import jd3_pkg::*;

    logic                         busy_reg, busy_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic                         valid_reg, valid_next;
    logic signed [MAC_A_W-1:0]    a_reg;
    logic        [MAC_B_W-1:0]    b_reg;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [CHUNK_W:0]      chunk;
    logic signed [CHUNK_W+MAC_B_W+1:0] prod;
    logic signed [ACC_W-1:0]      prod_ext;
    logic signed [ACC_W-1:0]      prod_sh;

    // chunk select: low chunks unsigned, top chunk carries the sign
    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    chunk = {1'b0, a_reg[CHUNK_W-1:0]};
            2'd1:    chunk = {1'b0, a_reg[2*CHUNK_W-1:CHUNK_W]};
            default: chunk = {a_reg[MAC_A_W-1], a_reg[MAC_A_W-1:2*CHUNK_W]};
        endcase
    end

    // partial product and shift into place
    always_comb
    begin
        prod     = chunk * $signed({1'b0, b_reg});
        prod_ext = ACC_W'(prod);
        unique case (cnt_reg)
            2'd0:    prod_sh = prod_ext;
            2'd1:    prod_sh = prod_ext <<< CHUNK_W;
            default: prod_sh = prod_ext <<< (2 * CHUNK_W);
        endcase
    end

    // sequencing
    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        valid_next = 1'b0;
        acc_next   = acc_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + prod_sh;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd2)
            begin
                busy_next  = 1'b0;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        acc_reg <= acc_next;
    end

    assign valid = valid_reg;
    assign acc   = acc_reg;

    // a new product never starts while one is under way
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n) go |-> !busy_reg)
        else $error("mac started while busy");
    // the third chunk always completes the product
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == 2'd2 && !go) |=> valid_reg)
        else $error("mac did not complete");
    // valid only follows a busy cycle
    a_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $past(busy_reg))
        else $error("mac valid without work");

endmodule
`default_nettype wire

// File: rtl/core/jd3_mem.sv
// source store and the two iterate stores, registered reads
`default_nettype none
module jd3_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic                              clk,
    input  wire jd3_pkg::mem_ctl_t                 ctl,
    input  wire logic [AW-1:0]                     src_waddr,
    input  wire logic [jd3_pkg::DATA_W-1:0]        src_wdata,
    input  wire logic [AW-1:0]                     src_raddr,
    output logic [jd3_pkg::DATA_W-1:0]             src_rdata,
    input  wire logic [AW-1:0]                     it_waddr,
    input  wire logic [jd3_pkg::DATA_W-1:0]        it_wdata,
    input  wire logic [AW-1:0]                     it_raddr,
    output logic [jd3_pkg::DATA_W-1:0]             it_rdata
);
    import jd3_pkg::*;

    logic [DATA_W-1:0] src_mem [DEPTH];
    logic [DATA_W-1:0] a_mem   [DEPTH];
    logic [DATA_W-1:0] b_mem   [DEPTH];
    logic [DATA_W-1:0] src_q;
    logic [DATA_W-1:0] a_q;
    logic [DATA_W-1:0] b_q;
    logic              rsel_q;

    // source store
    always_ff @(posedge clk)
    begin
        if (ctl.src_we)
            src_mem[src_waddr] <= src_wdata;
        src_q <= src_mem[src_raddr];
    end

    // iterate store a
    always_ff @(posedge clk)
    begin
        if (ctl.it_we && !ctl.it_wsel)
            a_mem[it_waddr] <= it_wdata;
        a_q <= a_mem[it_raddr];
    end

    // iterate store b
    always_ff @(posedge clk)
    begin
        if (ctl.it_we && ctl.it_wsel)
            b_mem[it_waddr] <= it_wdata;
        b_q <= b_mem[it_raddr];
        rsel_q <= ctl.it_rsel;
    end

    assign src_rdata = src_q;
    assign it_rdata  = rsel_q ? b_q : a_q;

endmodule
`default_nettype wire

// File: rtl/core/jacobi_diffusion_3d_stencil.sv
// top level: configuration, sequencer and datapath of the 3d jacobi diffusion block
//
// channel   direction  signals                                    handshake
// config    in         cfg_we, cfg_index, cfg_data                 written when cfg_we high
// command   in         start, action, cell_index, sample_value     taken when start && !busy
// result    out        done, read_value, saturated                 one-cycle strobe on done
//
// a write, an out-of-range read and an unused action raise done from the dispatch state,
// after the prep states; an in-range read passes through the read-wait state first
// a run first copies the source into iterate store a, then performs the configured
// sweeps; each interior cell needs six serial iterate-store reads and two products
// on the shared 3-chunk multiplier
// busy stays high for the whole transaction; the result strobe cannot be stalled
// reset clears configuration to defaults, result select and clip flag; stores hold junk
`default_nettype none
module jacobi_diffusion_3d_stencil #(
    parameter int MAX_X = jd3_pkg::DEF_MAX_X,
    parameter int MAX_Y = jd3_pkg::DEF_MAX_Y,
    parameter int MAX_Z = jd3_pkg::DEF_MAX_Z
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [2:0]                         cfg_index,
    input  wire logic [jd3_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         action,
    input  wire logic [jd3_pkg::IDX_W-1:0]          cell_index,
    input  wire logic signed [jd3_pkg::DATA_W-1:0]  sample_value,
    output logic                                    done,
    output logic signed [jd3_pkg::DATA_W-1:0]       read_value,
    output logic                                    saturated
);
    import jd3_pkg::*;

    localparam int EXT_X = (MAX_X < EXT_LIMIT) ? MAX_X : EXT_LIMIT;
    localparam int EXT_Y = (MAX_Y < EXT_LIMIT) ? MAX_Y : EXT_LIMIT;
    localparam int EXT_Z = (MAX_Z < EXT_LIMIT) ? MAX_Z : EXT_LIMIT;
    localparam int CELLS = EXT_X * EXT_Y * EXT_Z;
    localparam int AW    = $clog2(CELLS);

    // configuration registers
    logic [SIZE_W-1:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [SWEEP_W-1:0] sweeps_reg;
    logic [COUP_W-1:0]  coup_reg;
    logic [DIAG_W-1:0]  diag_reg;

    // sequencer state
    state_t                    state_reg, state_next;
    logic [1:0]                act_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [DATA_W-1:0]         val_reg;
    logic [XY_W-1:0]           sxy_reg, sxy_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          c_reg, c_next;
    logic [SIZE_W-1:0]         i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [SWEEP_W-1:0]        sweep_reg, sweep_next;
    logic [2:0]                nb_reg, nb_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [MAC_A_W-1:0] t_reg, t_next;
    logic                      sel_reg, sel_next;
    logic                      clip_reg, clip_next;
    logic                      done_reg, done_next;
    logic [DATA_W-1:0]         rv_reg, rv_next;

    // datapath signals
    logic [SIZE_W-1:0]         ex_x, ex_y, ex_z;
    logic [CNT_W-1:0]          idx_ext;
    logic                      in_range;
    logic                      border;
    logic                      last_i, last_j, last_k;
    logic [CNT_W-1:0]          nb_addr;
    mem_ctl_t                  mctl;
    logic [AW-1:0]             it_waddr, it_raddr;
    logic [DATA_W-1:0]         it_wdata;
    logic [DATA_W-1:0]         src_rdata, it_rdata;
    logic                      mac_go, mac_valid;
    logic signed [MAC_A_W-1:0] mac_a;
    logic [MAC_B_W-1:0]        mac_b;
    logic signed [ACC_W-1:0]   mac_acc;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [RND_W-1:0]   rnd;
    logic                      rnd_ovf;
    logic [DATA_W-1:0]         cell_val;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= RST_SIZE;
            size_y_reg <= RST_SIZE;
            size_z_reg <= RST_SIZE;
            sweeps_reg <= RST_SWEEPS;
            coup_reg   <= RST_COUP;
            diag_reg   <= RST_DIAG;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y: size_y_reg <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z: size_z_reg <= cfg_data[SIZE_W-1:0];
                CFG_SWEEPS: sweeps_reg <= cfg_data[SWEEP_W-1:0];
                CFG_COUP:   coup_reg   <= cfg_data[COUP_W-1:0];
                CFG_DIAG:   diag_reg   <= cfg_data[DIAG_W-1:0];
                default:    ;
            endcase
        end
    end

    // effective extents and range check
    assign ex_x     = extent(size_x_reg, SIZE_W'(EXT_X));
    assign ex_y     = extent(size_y_reg, SIZE_W'(EXT_Y));
    assign ex_z     = extent(size_z_reg, SIZE_W'(EXT_Z));
    assign idx_ext  = CNT_W'(idx_reg);
    assign in_range = idx_ext < n_reg;

    // cell position tests
    assign last_i = (i_reg == ex_x - SIZE_W'(1));
    assign last_j = (j_reg == ex_y - SIZE_W'(1));
    assign last_k = (k_reg == ex_z - SIZE_W'(1));
    assign border = (i_reg == '0) || (j_reg == '0) || (k_reg == '0)
                    || last_i || last_j || last_k;

    // neighbour address
    always_comb
    begin
        unique case (nb_reg)
            3'd0:    nb_addr = c_reg - CNT_W'(1);
            3'd1:    nb_addr = c_reg + CNT_W'(1);
            3'd2:    nb_addr = c_reg - CNT_W'(ex_x);
            3'd3:    nb_addr = c_reg + CNT_W'(ex_x);
            3'd4:    nb_addr = c_reg - CNT_W'(sxy_reg);
            3'd5:    nb_addr = c_reg + CNT_W'(sxy_reg);
            default: nb_addr = c_reg;
        endcase
    end

    // rounding of the accumulator and saturation
    always_comb
    begin
        acc_rnd = mac_acc + ACC_W'(32768);
        rnd     = acc_rnd[ACC_W-1:16];
        rnd_ovf = (rnd[RND_W-1:DATA_W-1] != '0) && (rnd[RND_W-1:DATA_W-1] != '1);
        if (!rnd_ovf)
            cell_val = rnd[DATA_W-1:0];
        else if (rnd[RND_W-1])
            cell_val = {1'b1, {(DATA_W-1){1'b0}}};
        else
            cell_val = {1'b0, {(DATA_W-1){1'b1}}};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sxy_next   = sxy_reg;
        n_next     = n_reg;
        c_next     = c_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        sweep_next = sweep_reg;
        nb_next    = nb_reg;
        sum_next   = sum_reg;
        t_next     = t_reg;
        sel_next   = sel_reg;
        clip_next  = clip_reg;
        done_next  = 1'b0;
        rv_next    = rv_reg;
        mctl       = '0;
        it_waddr   = c_reg[AW-1:0];
        it_wdata   = '0;
        it_raddr   = nb_addr[AW-1:0];
        mac_go     = 1'b0;
        mac_a      = MAC_A_W'(sum_reg);
        mac_b      = coup_reg;
        mctl.it_rsel = sel_reg;
        mctl.it_wsel = !sel_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_PREP_XY;
            end
            ST_PREP_XY:
            begin
                sxy_next   = ex_x * ex_y;
                state_next = ST_PREP_N;
            end
            ST_PREP_N:
            begin
                n_next     = sxy_reg * ex_z;
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                rv_next = '0;
                priority if (act_reg == ACT_WRITE)
                begin
                    mctl.src_we = in_range;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (act_reg == ACT_READ)
                begin
                    it_raddr = idx_ext[AW-1:0];
                    if (in_range)
                        state_next = ST_READ_WAIT;
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (act_reg == ACT_RUN)
                begin
                    clip_next  = 1'b0;
                    sel_next   = 1'b0;
                    c_next     = '0;
                    state_next = ST_COPY_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ_WAIT:
            begin
                rv_next    = it_rdata;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_COPY_RD:
                state_next = ST_COPY_WR;
            ST_COPY_WR:
            begin
                // source copied into iterate store a
                mctl.it_we   = 1'b1;
                mctl.it_wsel = 1'b0;
                it_wdata     = src_rdata;
                if (c_reg == n_reg - CNT_W'(1))
                begin
                    c_next     = '0;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    sweep_next = '0;
                    if (sweeps_reg == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_CELL;
                end
                else
                begin
                    c_next     = c_reg + CNT_W'(1);
                    state_next = ST_COPY_RD;
                end
            end
            ST_CELL:
            begin
                sum_next = '0;
                nb_next  = '0;
                if (!border)
                    state_next = ST_NB;
            end
            ST_NB:
            begin
                // one neighbour read issued per cycle, its registered data added on the following cycle
                if (nb_reg != 3'd0)
                    sum_next = sum_reg + SUM_W'($signed(it_rdata));
                nb_next = nb_reg + 3'd1;
                if (nb_reg == 3'd6)
                    state_next = ST_MUL1_GO;
            end
            ST_MUL1_GO:
            begin
                mac_go     = 1'b1;
                state_next = ST_MUL1_WAIT;
            end
            ST_MUL1_WAIT:
            begin
                t_next = MAC_A_W'($signed(src_rdata)) + MAC_A_W'(rnd);
                if (mac_valid)
                    state_next = ST_MUL2_GO;
            end
            ST_MUL2_GO:
            begin
                mac_go     = 1'b1;
                mac_a      = t_reg;
                mac_b      = MAC_B_W'(diag_reg);
                state_next = ST_MUL2_WAIT;
            end
            ST_MUL2_WAIT:
            begin
                if (mac_valid)
                begin
                    mctl.it_we = 1'b1;
                    it_wdata   = cell_val;
                    if (rnd_ovf)
                        clip_next = 1'b1;
                    state_next = ST_CELL;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // border write and scan advance share one path
        if ((state_reg == ST_CELL && border) || (state_reg == ST_MUL2_WAIT && mac_valid))
        begin
            if (state_reg == ST_CELL)
                mctl.it_we = 1'b1;
            c_next     = c_reg + CNT_W'(1);
            state_next = ST_CELL;
            if (!last_i)
                i_next = i_reg + SIZE_W'(1);
            else
            begin
                i_next = '0;
                if (!last_j)
                    j_next = j_reg + SIZE_W'(1);
                else
                begin
                    j_next = '0;
                    if (!last_k)
                        k_next = k_reg + SIZE_W'(1);
                    else
                    begin
                        // end of a sweep
                        k_next     = '0;
                        c_next     = '0;
                        sel_next   = !sel_reg;
                        sweep_next = sweep_reg + SWEEP_W'(1);
                        if (sweep_reg + SWEEP_W'(1) == sweeps_reg)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
            clip_reg  <= 1'b0;
            done_reg  <= 1'b0;
            c_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            sweep_reg <= '0;
            nb_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            clip_reg  <= clip_next;
            done_reg  <= done_next;
            c_reg     <= c_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            sweep_reg <= sweep_next;
            nb_reg    <= nb_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            act_reg <= action;
            idx_reg <= cell_index;
            val_reg <= sample_value;
        end
        sxy_reg <= sxy_next;
        n_reg   <= n_next;
        sum_reg <= sum_next;
        t_reg   <= t_next;
        rv_reg  <= rv_next;
    end

    jd3_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .ctl       (mctl),
        .src_waddr (idx_ext[AW-1:0]),
        .src_wdata (val_reg),
        .src_raddr (c_reg[AW-1:0]),
        .src_rdata (src_rdata),
        .it_waddr  (it_waddr),
        .it_wdata  (it_wdata),
        .it_raddr  (it_raddr),
        .it_rdata  (it_rdata)
    );

    jd3_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mac_go),
        .a     (mac_a),
        .b     (mac_b),
        .valid (mac_valid),
        .acc   (mac_acc)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign read_value = rv_reg;
    assign saturated  = clip_reg;

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");
    // the result shows only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy)
        else $error("result while busy");
    // an accepted transaction makes the block busy
    a_accept: assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not start");
    // iterate stores are only written during a run
    a_it_write: assert property (@(posedge clk) disable iff (!rst_n) mctl.it_we |-> busy)
        else $error("iterate write while idle");

endmodule
`default_nettype wire
